// File: rtl/sof_pkg.sv
// Package for the spectral oversubtraction factor block.
// Holds the controller states, command and status structs, configuration
// layout, fixed-point constants and the log2 table. No dependencies.
package sof_pkg;

    localparam int NW       = 46;   // normalizer width, holds a saturated sum plus one
    localparam int SUM_W    = 44;
    localparam int LOG_W    = 22;   // log2 in Q.16, at most 46 * 2^16
    localparam int MUL_W    = 28;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DIV_NW   = 38;
    localparam int DEN_W    = 17;
    localparam int REM_W    = 18;
    localparam int DIV_BITS = 2;    // quotient bits per cycle
    localparam int DIV_ITERS = DIV_NW / DIV_BITS;
    localparam int NORM_STEPS = 6;

    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_BIN    = 2'd1;
    localparam logic [1:0] MODE_GLOBAL = 2'd2;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_STRENGTH = 3'd1;
    localparam logic [2:0] REG_UNDERSUB = 3'd2;
    localparam logic [2:0] REG_AMIN     = 3'd3;
    localparam logic [2:0] REG_AMAX     = 3'd4;
    localparam logic [2:0] REG_LO_DB    = 3'd5;
    localparam logic [2:0] REG_HI_DB    = 3'd6;

    localparam logic [25:0] DB_PER_LOG2 = 26'd50504453;
    localparam logic signed [15:0] DB_LOWEST  = -16'sd32768;
    localparam logic signed [15:0] DB_HIGHEST = 16'sd32767;
    localparam logic signed [15:0] GLOBAL_HIGH_DB = 16'sd5120;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_NLOAD, ST_NSTEP, ST_LMUL, ST_LADD, ST_DMUL,
        ST_SNR, ST_DECIDE, ST_SMUL, ST_TOP, ST_SPAN, ST_GHI, ST_GLO,
        ST_DLOAD, ST_DSTEP, ST_RESULT
    } state_t;

    typedef enum logic [2:0] {
        MUL_LOG, MUL_DB, MUL_SCALE, MUL_SPAN, MUL_GHI, MUL_GLO
    } mul_sel_t;

    typedef enum logic [2:0] {
        RES_MIN, RES_TOP, RES_BIN, RES_GMAX, RES_GMIN, RES_GDIV
    } res_sel_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [15:0]        strength;
        logic [15:0]        undersub;
        logic [15:0]        amin;
        logic [15:0]        amax;
        logic signed [15:0] lo_db;
        logic signed [15:0] hi_db;
    } cfg_t;

    typedef struct packed {
        logic     load_in;
        logic     norm_load;
        logic     norm_sel;     // 0 reference, 1 noise
        logic     norm_step;
        logic     mul_go;
        mul_sel_t mul_sel;
        logic     log_store;
        logic     snr_store;
        logic     top_store;
        logic     div_load;
        logic     div_global;
        logic     div_step;
        logic     res_load;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic ref_zero;
        logic norm_last;
        logic div_last;
        logic snr_le_lo;
        logic snr_ge_hi;
        logic snr_le_0;
        logic snr_ge_g;
        logic out_free;
    } stat_t;

    function automatic logic [16:0] log2_tab(input logic [4:0] i);
        logic [16:0] v;
        unique case (i)
            5'd0:  v = 17'd0;
            5'd1:  v = 17'd5732;
            5'd2:  v = 17'd11136;
            5'd3:  v = 17'd16248;
            5'd4:  v = 17'd21098;
            5'd5:  v = 17'd25711;
            5'd6:  v = 17'd30109;
            5'd7:  v = 17'd34312;
            5'd8:  v = 17'd38336;
            5'd9:  v = 17'd42196;
            5'd10: v = 17'd45904;
            5'd11: v = 17'd49472;
            5'd12: v = 17'd52911;
            5'd13: v = 17'd56229;
            5'd14: v = 17'd59434;
            5'd15: v = 17'd62534;
            5'd16: v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [39:0] v);
        logic [15:0] r;
        if (v < 40'sd0) begin
            r = 16'd0;
        end else if (v > 40'sd65535) begin
            r = 16'hFFFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/sof_ctrl.sv
// Controller of the oversubtraction factor block: sequences the shared
// datapath through log, dB, interpolation and division steps.
// Depends on sof_pkg.
module sof_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [1:0]     mode,
    input  sof_pkg::stat_t stat,
    output sof_pkg::cmd_t  cmd
);
    import sof_pkg::*;

    state_t   state_reg, state_next;
    logic     nsel_reg, nsel_next;
    res_sel_t res_reg, res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            nsel_reg  <= 1'b0;
            res_reg   <= RES_MIN;
        end else begin
            state_reg <= state_next;
            nsel_reg  <= nsel_next;
            res_reg   <= res_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        nsel_next  = nsel_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                nsel_next = 1'b0;
                if (mode != MODE_BIN && mode != MODE_GLOBAL) begin
                    res_next   = RES_MIN;
                    state_next = ST_RESULT;
                end else if (mode == MODE_GLOBAL && !stat.last) begin
                    state_next = ST_IDLE;
                end else if (stat.ref_zero) begin
                    state_next = ST_SNR;
                end else begin
                    state_next = ST_NLOAD;
                end
            end
            ST_NLOAD: state_next = ST_NSTEP;
            ST_NSTEP: begin
                if (stat.norm_last) state_next = ST_LMUL;
            end
            ST_LMUL: state_next = ST_LADD;
            ST_LADD: begin
                if (!nsel_reg) begin
                    nsel_next  = 1'b1;
                    state_next = ST_NLOAD;
                end else begin
                    state_next = ST_DMUL;
                end
            end
            ST_DMUL: state_next = ST_SNR;
            ST_SNR:  state_next = ST_DECIDE;
            ST_DECIDE: begin
                priority if (mode == MODE_BIN) begin
                    state_next = ST_SMUL;
                end else if (stat.snr_le_0) begin
                    res_next   = RES_GMAX;
                    state_next = ST_RESULT;
                end else if (stat.snr_ge_g) begin
                    res_next   = RES_GMIN;
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_GHI;
                end
            end
            ST_SMUL: state_next = ST_TOP;
            ST_TOP: begin
                priority if (stat.snr_le_lo) begin
                    res_next   = RES_TOP;
                    state_next = ST_RESULT;
                end else if (stat.snr_ge_hi) begin
                    res_next   = RES_MIN;
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN: state_next = ST_DLOAD;
            ST_GHI:  state_next = ST_GLO;
            ST_GLO:  state_next = ST_DLOAD;
            ST_DLOAD: state_next = ST_DSTEP;
            ST_DSTEP: begin
                if (stat.div_last) begin
                    res_next   = (mode == MODE_GLOBAL) ? RES_GDIV : RES_BIN;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd            = '0;
        cmd.mul_sel    = MUL_LOG;
        cmd.res_sel    = res_reg;
        cmd.norm_sel   = nsel_reg;
        cmd.div_global = (mode == MODE_GLOBAL);
        s_tready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_NLOAD: cmd.norm_load = 1'b1;
            ST_NSTEP: cmd.norm_step = 1'b1;
            ST_LMUL: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_LOG;
            end
            ST_LADD: cmd.log_store = 1'b1;
            ST_DMUL: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_DB;
            end
            ST_SNR: cmd.snr_store = 1'b1;
            ST_SMUL: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_SCALE;
            end
            ST_TOP: cmd.top_store = 1'b1;
            ST_SPAN: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_SPAN;
            end
            ST_GHI: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_GHI;
            end
            ST_GLO: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_GLO;
            end
            ST_DLOAD: cmd.div_load = 1'b1;
            ST_DSTEP: cmd.div_step = 1'b1;
            ST_RESULT: cmd.res_load = stat.out_free;
            default: ;
        endcase
    end

endmodule

// File: rtl/sof_datapath.sv
// Datapath of the oversubtraction factor block: frame sums, log2 normalizer,
// one shared multiplier, a two-bit-per-cycle divider and the result register.
// Depends on sof_pkg.
module sof_datapath #(
    parameter int POWER_BITS = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  sof_pkg::cfg_t  cfg,
    input  sof_pkg::cmd_t  cmd,
    output sof_pkg::stat_t stat,
    input  logic [31:0]    in_ref,
    input  logic [31:0]    in_noise,
    input  logic           in_last,
    input  logic           out_ready,
    output logic           out_valid,
    output logic [15:0]    out_alpha,
    output logic [15:0]    out_beta,
    output logic           out_wide,
    output logic           out_last
);
    import sof_pkg::*;

    localparam logic [31:0] PMASK = (POWER_BITS >= 32) ? 32'hFFFF_FFFF :
                                    32'((64'd1 << POWER_BITS) - 64'd1);
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Frame sums and working operands.
    logic [SUM_W-1:0] sum_ref_reg, sum_noise_reg, xr_reg, xn_reg;
    logic             last_reg;
    logic [SUM_W:0]   ref_add, noise_add;
    logic [SUM_W-1:0] ref_sat, noise_sat;
    logic [31:0]      ref_m, noise_m;

    assign ref_m     = in_ref & PMASK;
    assign noise_m   = in_noise & PMASK;
    assign ref_add   = {1'b0, sum_ref_reg} + (SUM_W + 1)'(ref_m);
    assign noise_add = {1'b0, sum_noise_reg} + (SUM_W + 1)'(noise_m);
    assign ref_sat   = ref_add[SUM_W] ? SUM_MAX : ref_add[SUM_W-1:0];
    assign noise_sat = noise_add[SUM_W] ? SUM_MAX : noise_add[SUM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_ref_reg   <= '0;
            sum_noise_reg <= '0;
        end else if (cmd.load_in) begin
            sum_ref_reg   <= in_last ? '0 : ref_sat;
            sum_noise_reg <= in_last ? '0 : noise_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            last_reg <= in_last;
            xr_reg   <= (cfg.mode == MODE_GLOBAL) ? ref_sat : SUM_W'(ref_m);
            xn_reg   <= (cfg.mode == MODE_GLOBAL) ? noise_sat : SUM_W'(noise_m);
        end
    end

    // Normalizer: shifts by 32, 16, 8, 4, 2, 1 until the leading one is on top.
    logic [NW-1:0] w_reg;
    logic [5:0]    sh_reg;
    logic [2:0]    ncnt_reg;
    logic [5:0]    amt;
    logic          hi_zero;

    assign amt     = 6'd32 >> ncnt_reg;
    assign hi_zero = ((w_reg >> (7'(NW) - 7'(amt))) == '0);

    always_ff @(posedge aclk) begin
        if (cmd.norm_load) begin
            w_reg    <= cmd.norm_sel ? NW'({1'b0, xn_reg} + (SUM_W + 1)'(1)) : NW'(xr_reg);
            sh_reg   <= '0;
            ncnt_reg <= '0;
        end else if (cmd.norm_step) begin
            ncnt_reg <= ncnt_reg + 3'd1;
            if (hi_zero) begin
                w_reg  <= w_reg << amt;
                sh_reg <= sh_reg + amt;
            end
        end
    end

    logic [3:0]       tidx;
    logic [15:0]      trem;
    logic [16:0]      ta, tb;
    logic [5:0]       expo;
    logic [LOG_W-1:0] log_val, lr_reg, ln_reg;

    assign tidx    = w_reg[NW-2 -: 4];
    assign trem    = w_reg[NW-6 -: 16];
    assign ta      = log2_tab({1'b0, tidx});
    assign tb      = log2_tab(5'({1'b0, tidx}) + 5'd1);
    assign expo    = 6'(NW - 1) - sh_reg;

    // Shared multiplier with a registered product.
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_reg, prod_new;
    logic signed [15:0]       snr_reg;
    logic signed [23:0]       xs_reg, top_reg;
    logic signed [16:0]       amp_diff;
    logic signed [17:0]       snr_lo, g_hi;
    logic signed [LOG_W:0]    dlog;
    logic [LOG_W-1:0]         dmag;

    assign log_val  = LOG_W'({expo, 16'd0}) + LOG_W'(ta) + LOG_W'(prod_reg[31:16]);
    assign amp_diff = $signed({1'b0, cfg.amax}) - $signed({1'b0, cfg.amin});
    assign snr_lo   = 18'(snr_reg) - 18'(cfg.lo_db);
    assign g_hi     = 18'(GLOBAL_HIGH_DB) - 18'(snr_reg);
    assign dlog     = $signed({1'b0, lr_reg}) - $signed({1'b0, ln_reg});
    assign dmag     = dlog[LOG_W] ? LOG_W'(-dlog) : LOG_W'(dlog);

    always_comb begin
        unique case (cmd.mul_sel)
            MUL_LOG: begin
                mul_a = MUL_W'(tb - ta);
                mul_b = MUL_W'(trem);
            end
            MUL_DB: begin
                mul_a = MUL_W'(dmag);
                mul_b = MUL_W'(DB_PER_LOG2);
            end
            MUL_SCALE: begin
                mul_a = MUL_W'(cfg.strength);
                mul_b = MUL_W'(amp_diff);
            end
            MUL_SPAN: begin
                mul_a = MUL_W'(snr_lo);
                mul_b = MUL_W'(xs_reg);
            end
            MUL_GHI: begin
                mul_a = MUL_W'(g_hi);
                mul_b = MUL_W'(cfg.strength);
            end
            MUL_GLO: begin
                mul_a = MUL_W'(snr_reg);
                mul_b = MUL_W'(cfg.amin);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_new = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (cmd.mul_go) begin
            prod_reg <= (cmd.mul_sel == MUL_GLO) ? prod_reg + prod_new : prod_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.log_store) begin
            if (cmd.norm_sel) ln_reg <= log_val;
            else lr_reg <= log_val;
        end
    end

    // dB value from the product, rounded, clamped, sign restored.
    logic [PROD_W-1:0]     prod_abs, db_round;
    logic [17:0]           qdb;
    logic signed [15:0]    snr_val;

    assign prod_abs = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign db_round = PROD_W'(prod_reg) + PROD_W'(64'h8000_0000);
    assign qdb      = db_round[49:32];

    always_comb begin
        if (stat.ref_zero) begin
            snr_val = DB_LOWEST;
        end else if (dlog[LOG_W]) begin
            snr_val = (qdb > 18'd32768) ? DB_LOWEST : 16'(-$signed({1'b0, qdb}));
        end else begin
            snr_val = (qdb > 18'd32767) ? DB_HIGHEST : 16'(qdb);
        end
    end

    // Scaled maximum: rounded product / 4096, halves away from zero.
    logic [PROD_W-1:0] scale_mag;
    logic signed [23:0] xs_val;

    assign scale_mag = (prod_abs + PROD_W'(2048)) >> 12;
    assign xs_val    = prod_reg[PROD_W-1] ? -24'(scale_mag) : 24'(scale_mag);

    always_ff @(posedge aclk) begin
        if (cmd.snr_store) snr_reg <= snr_val;
        if (cmd.top_store) begin
            xs_reg  <= xs_val;
            top_reg <= 24'(cfg.amin) + xs_val;
        end
    end

    // Restoring divider, two quotient bits a cycle.
    logic [DIV_NW-1:0] dnum_reg, dnum_nx;
    logic [REM_W-1:0]  rem_reg, rem_nx;
    logic [DEN_W-1:0]  den_reg, den_val;
    logic              dneg_reg;
    logic [4:0]        dcnt_reg;
    logic signed [DEN_W-1:0] span;

    assign span    = DEN_W'(cfg.hi_db) - DEN_W'(cfg.lo_db);
    assign den_val = cmd.div_global ? DEN_W'(GLOBAL_HIGH_DB) : DEN_W'(span);

    always_comb begin
        dnum_nx = dnum_reg;
        rem_nx  = rem_reg;
        for (int k = 0; k < DIV_BITS; k++) begin
            rem_nx  = {rem_nx[REM_W-2:0], dnum_nx[DIV_NW-1]};
            dnum_nx = {dnum_nx[DIV_NW-2:0], 1'b0};
            if (rem_nx >= REM_W'(den_reg)) begin
                rem_nx     = rem_nx - REM_W'(den_reg);
                dnum_nx[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            den_reg  <= den_val;
            dneg_reg <= prod_reg[PROD_W-1];
            dnum_reg <= DIV_NW'(prod_abs) + DIV_NW'(den_val >> 1);
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            dnum_reg <= dnum_nx;
            rem_reg  <= rem_nx;
            dcnt_reg <= dcnt_reg + 5'd1;
        end
    end

    // Result selection and output register.
    logic signed [39:0] quo, bin_val;
    logic [15:0]        alpha_sel;
    logic               glob;

    assign quo     = 40'($signed({1'b0, dnum_reg}));
    assign bin_val = 40'(top_reg) - (dneg_reg ? -quo : quo);
    assign glob    = (cmd.res_sel == RES_GMAX) || (cmd.res_sel == RES_GMIN) ||
                     (cmd.res_sel == RES_GDIV);

    always_comb begin
        unique case (cmd.res_sel)
            RES_MIN:  alpha_sel = cfg.amin;
            RES_TOP:  alpha_sel = sat16(40'(top_reg));
            RES_BIN:  alpha_sel = sat16(bin_val);
            RES_GMAX: alpha_sel = cfg.strength;
            RES_GMIN: alpha_sel = cfg.amin;
            RES_GDIV: alpha_sel = sat16(quo);
            default:  alpha_sel = cfg.amin;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (cmd.res_load) begin
            out_valid <= 1'b1;
        end else if (out_ready) begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            out_alpha <= alpha_sel;
            out_beta  <= glob ? cfg.undersub : 16'd0;
            out_wide  <= glob;
            out_last  <= last_reg;
        end
    end

    assign stat.last      = last_reg;
    assign stat.ref_zero  = (xr_reg == '0);
    assign stat.norm_last = (ncnt_reg == 3'(NORM_STEPS - 1));
    assign stat.div_last  = (dcnt_reg == 5'(DIV_ITERS - 1));
    assign stat.snr_le_lo = (snr_reg <= cfg.lo_db);
    assign stat.snr_ge_hi = (snr_reg >= cfg.hi_db);
    assign stat.snr_le_0  = (snr_reg <= 16'sd0);
    assign stat.snr_ge_g  = (snr_reg >= GLOBAL_HIGH_DB);
    assign stat.out_free  = !out_valid || out_ready;

endmodule

// File: rtl/spectral_oversubtraction_factor.sv
// Top level of the spectral oversubtraction factor block.
// Holds the configuration registers and joins sof_ctrl and sof_datapath.
// Depends on sof_pkg, sof_ctrl and sof_datapath.
//
// Usage: one spectral bin is a transfer on the s_ channel: reference power and
// noise power in s_tdata, the last bin of a frame flagged by s_tlast. Each bin
// yields at most one result transfer on the m_ channel: alpha and beta in
// m_tdata, the frame-wide flag in m_tuser and a copy of the last flag in m_tlast.
// In global mode only the last bin of a frame gives a result; the frame sums
// are kept for every bin in every mode and cleared after each last bin.
// The block works on one bin at a time and takes no new bin before it is through
// with the last one. A bin in mode none goes straight to the result register.
// A per-bin SNR bin passes through two log2 evaluations with a six-step
// normalizer each, a shared multiplier, and a restoring divider that retires
// two quotient bits a cycle. Global results on the last bin use the same log2
// evaluations, multiplier and divider; other global bins give no result.
// The result waits in an output register; a bin may be accepted while it waits,
// and a finished result stalls until the receiver takes the pending one.
// Synchronous active-low reset empties the output register, clears the frame
// sums and loads the register defaults. Configuration is written through
// cfg_wr_en, cfg_addr and cfg_wdata while no bin is in flight.
module spectral_oversubtraction_factor #(
    parameter int POWER_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // reference_power [31:0], noise_power [63:32]
    input  logic        s_tlast,   // last_bin
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // alpha_factor [15:0], beta_factor [31:16]
    output logic        m_tuser,   // frame_wide
    output logic        m_tlast,   // last_of_frame
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import sof_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;
    logic [15:0] alpha, beta;

    // Register writes take effect at the clock edge; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode     <= MODE_NONE;
            cfg_reg.strength <= 16'd4096;
            cfg_reg.undersub <= 16'd0;
            cfg_reg.amin     <= 16'd4096;
            cfg_reg.amax     <= 16'd24576;
            cfg_reg.lo_db    <= -16'sd1280;
            cfg_reg.hi_db    <= 16'sd5120;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MODE:     cfg_reg.mode     <= cfg_wdata[1:0];
                REG_STRENGTH: cfg_reg.strength <= cfg_wdata;
                REG_UNDERSUB: cfg_reg.undersub <= cfg_wdata;
                REG_AMIN:     cfg_reg.amin     <= cfg_wdata;
                REG_AMAX:     cfg_reg.amax     <= cfg_wdata;
                REG_LO_DB:    cfg_reg.lo_db    <= cfg_wdata;
                REG_HI_DB:    cfg_reg.hi_db    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    sof_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (cfg_reg.mode),
        .stat     (stat),
        .cmd      (cmd)
    );

    sof_datapath #(
        .POWER_BITS (POWER_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .stat      (stat),
        .in_ref    (s_tdata[31:0]),
        .in_noise  (s_tdata[63:32]),
        .in_last   (s_tlast),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_alpha (alpha),
        .out_beta  (beta),
        .out_wide  (m_tuser),
        .out_last  (m_tlast)
    );

    assign m_tdata = {beta, alpha};

    // A frame-wide result only ever comes from the last bin of a frame.
    a_wide_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame-wide result not marked last");

    // Frame-wide results are produced only in global mode.
    a_wide_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> cfg_reg.mode == MODE_GLOBAL)
        else $error("frame-wide result outside global mode");

    // Per-bin and pass-through results carry a zero beta.
    a_beta_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[31:16] == 16'd0)
        else $error("nonzero beta on a per-bin result");

endmodule

// File: tb/tb_spectral_oversubtraction_factor.sv
// Self-checking testbench for spectral_oversubtraction_factor.
// Predicts alpha, beta and the flags of every result and compares them in order.
// Depends on sof_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_spectral_oversubtraction_factor;
    import sof_pkg::*;

    localparam longint SUM_LIMIT = (64'd1 << 44) - 1;
    localparam int TIMEOUT_CYCLES = 2000000;

    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] beta;
        logic        wide;
        logic        last;
    } factor_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    spectral_oversubtraction_factor dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // Shadow copy of the configuration and the frame sums.
    logic [1:0]         mode_q;
    logic [15:0]        strength_q, undersub_q, amin_q, amax_q;
    logic signed [15:0] lo_db_q, hi_db_q;
    longint unsigned    ref_total, noise_total;

    factor_t expected_factors[$];
    int      error_count;
    int      bins_sent;
    int      results_seen;
    int      cycle_count;
    bit      hold_off;     // long receiver stall requested by a test
    bit      quiet_run;    // no random idling on either side

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("Timeout at %0t", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Base-2 logarithm in Q.16 from the 17-entry table with interpolation.
    function automatic longint log2_q16(input longint unsigned x);
        int e;
        longint unsigned f, rem;
        longint unsigned a, b;
        e = 0;
        while (e < 63 && (x >> (e + 1)) != 0) e++;
        f = x << (63 - e);
        a = log2_tab(5'((f >> 59) & 15));
        b = log2_tab(5'(((f >> 59) & 15) + 1));
        rem = (f >> 43) & 16'hFFFF;
        return (longint'(e) << 16) + longint'(a) + longint'(((b - a) * rem) >> 16);
    endfunction

    function automatic longint snr_q8(input longint unsigned pr, input longint unsigned pn);
        longint d;
        longint unsigned m, q;
        if (pr == 0) return -32768;
        d = log2_q16(pr) - log2_q16(pn + 1);
        m = (d < 0) ? longint'(-d) : longint'(d);
        q = (m * 64'd50504453 + 64'h80000000) >> 32;
        if (d < 0) return (q > 32768) ? -32768 : -longint'(q);
        return (q > 32767) ? 32767 : longint'(q);
    endfunction

    // Division rounded to nearest, halves away from zero; den is positive.
    function automatic longint round_div(input longint num, input longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic logic [15:0] clamp16(input longint v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    // Updates the frame sums and returns 1 with the factors when the bin gives a result.
    function automatic bit predict_factors(input logic [31:0] pr, input logic [31:0] pn,
                                           input logic lst, output factor_t res);
        longint s, top, lo, hi, amin;
        bit gives;
        res = '{alpha: amin_q, beta: 16'd0, wide: 1'b0, last: lst};
        gives = 1'b1;
        ref_total = ref_total + pr;
        if (ref_total > SUM_LIMIT) ref_total = SUM_LIMIT;
        noise_total = noise_total + pn;
        if (noise_total > SUM_LIMIT) noise_total = SUM_LIMIT;
        if (mode_q == MODE_GLOBAL) begin
            if (!lst) begin
                gives = 1'b0;
            end else begin
                s = snr_q8(ref_total, noise_total);
                if (s <= 0) res.alpha = strength_q;
                else if (s >= 5120) res.alpha = amin_q;
                else res.alpha = clamp16(round_div((5120 - s) * longint'(strength_q)
                                                   + s * longint'(amin_q), 5120));
                res.beta = undersub_q;
                res.wide = 1'b1;
            end
        end else if (mode_q == MODE_BIN) begin
            lo = lo_db_q;
            hi = hi_db_q;
            amin = amin_q;
            top = amin + round_div(longint'(strength_q) * (longint'(amax_q) - amin), 4096);
            s = snr_q8(pr, pn);
            if (s <= lo) res.alpha = clamp16(top);
            else if (s >= hi) res.alpha = amin_q;
            else res.alpha = clamp16(top - round_div((s - lo) * (top - amin), hi - lo));
        end
        if (lst) begin
            ref_total = 0;
            noise_total = 0;
        end
        return gives;
    endfunction

    // Writes one register at the next rising edge; called only while the block is idle.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_MODE:     mode_q     = val[1:0];
            REG_STRENGTH: strength_q = val;
            REG_UNDERSUB: undersub_q = val;
            REG_AMIN:     amin_q     = val;
            REG_AMAX:     amax_q     = val;
            REG_LO_DB:    lo_db_q    = val;
            REG_HI_DB:    hi_db_q    = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [1:0] md, input logic [15:0] st, input logic [15:0] us,
                             input logic [15:0] amn, input logic [15:0] amx,
                             input logic [15:0] lo, input logic [15:0] hi);
        write_reg(REG_MODE, {14'd0, md});
        write_reg(REG_STRENGTH, st);
        write_reg(REG_UNDERSUB, us);
        write_reg(REG_AMIN, amn);
        write_reg(REG_AMAX, amx);
        write_reg(REG_LO_DB, lo);
        write_reg(REG_HI_DB, hi);
    endtask

    // Offers one bin, holding it until the transfer, then records its prediction.
    task automatic send_bin(input logic [31:0] pr, input logic [31:0] pn, input logic lst);
        factor_t res;
        while (!quiet_run && $urandom_range(99) < 22) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  <= {pn, pr};
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (predict_factors(pr, pn, lst, res)) expected_factors.push_back(res);
        bins_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Waits until every result is in, then lets an unanswered bin finish.
    task automatic drain;
        while (expected_factors.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    // Random power with weight on small values, zero and full scale.
    function automatic logic [31:0] rand_power;
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(255);
            3: return $urandom >> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (!aresetn || hold_off) m_tready <= 1'b0;
        else m_tready <= quiet_run ? 1'b1 : ($urandom_range(99) >= 22);
    end

    // Result checker.
    always @(posedge aclk) begin
        factor_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{alpha: m_tdata[15:0], beta: m_tdata[31:16], wide: m_tuser, last: m_tlast};
            results_seen++;
            if (expected_factors.size() == 0) begin
                $display("%0t: unexpected result alpha=%0d beta=%0d", $time, got.alpha, got.beta);
                error_count++;
            end else begin
                want = expected_factors.pop_front();
                if (got.alpha !== want.alpha) begin
                    $display("%0t: alpha expected %0d actual %0d", $time, want.alpha, got.alpha);
                    error_count++;
                end
                if (got.beta !== want.beta) begin
                    $display("%0t: beta expected %0d actual %0d", $time, want.beta, got.beta);
                    error_count++;
                end
                if (got.wide !== want.wide) begin
                    $display("%0t: frame_wide expected %0b actual %0b", $time, want.wide,
                             got.wide);
                    error_count++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    // Extremes of the powers in every mode with the reset settings.
    task automatic test_directed_extremes;
        logic [1:0] md;
        for (int m = 0; m < 4; m++) begin
            md = m[1:0];
            write_reg(REG_MODE, {14'd0, md});
            send_bin(32'd0, 32'd0, 1'b0);
            send_bin(32'hFFFF_FFFF, 32'd0, 1'b0);
            send_bin(32'd0, 32'hFFFF_FFFF, 1'b0);
            send_bin(32'd1000, 32'd10, 1'b0);
            send_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
            drain();
        end
    endtask

    // Per-bin mode with an inverted window and a maximum factor below the minimum.
    task automatic test_bin_windows;
        write_all(MODE_BIN, 16'hFFFF, 16'd0, 16'd30000, 16'd100, 16'h8000, 16'h7FFF);
        send_bin(32'd0, 32'd5, 1'b1);
        send_bin(32'd5000, 32'd4, 1'b1);
        drain();
        write_reg(REG_LO_DB, 16'h0A00);
        write_reg(REG_HI_DB, 16'h0100);
        write_reg(REG_AMAX, 16'hFFFF);
        write_reg(REG_AMIN, 16'd0);
        send_bin(32'd10, 32'd100, 1'b0);
        send_bin(32'd100000, 32'd1, 1'b1);
        drain();
    endtask

    // A long global frame with large sums, plus a long receiver stall.
    task automatic test_global_long_frame;
        write_all(MODE_GLOBAL, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
        for (int i = 0; i < 800; i++) send_bin(32'hFFFF_FFFF, 32'd7, i == 799);
        drain();
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 40; i++) send_bin(rand_power(), rand_power(), 1'b1);
        join
        drain();
    endtask

    // Random frames under random settings, with one phase run at full rate.
    task automatic test_random_frames;
        int frame_len;
        for (int phase = 0; phase < 10; phase++) begin
            quiet_run = (phase == 7);
            write_all(2'($urandom_range(3)), 16'($urandom), 16'($urandom),
                      16'($urandom_range(16384)), 16'($urandom), 16'($urandom),
                      16'($urandom));
            if ($urandom_range(1)) begin
                write_reg(REG_LO_DB, 16'($signed($urandom_range(6000)) - 2000));
                write_reg(REG_HI_DB, 16'(lo_db_q + $urandom_range(8000)));
            end
            for (int n = 0; n < 120; ) begin
                frame_len = $urandom_range(1, 8);
                for (int k = 0; k < frame_len; k++) begin
                    send_bin(rand_power(), rand_power(), k == frame_len - 1);
                    n++;
                end
            end
            drain();
        end
        quiet_run = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_MODE;
        cfg_wdata = '0;
        hold_off = 1'b0;
        quiet_run = 1'b0;
        error_count = 0;
        bins_sent = 0;
        results_seen = 0;
        cycle_count = 0;
        mode_q = MODE_NONE;
        strength_q = 16'd4096;
        undersub_q = 16'd0;
        amin_q = 16'd4096;
        amax_q = 16'd24576;
        lo_db_q = -16'sd1280;
        hi_db_q = 16'sd5120;
        ref_total = 0;
        noise_total = 0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed_extremes();
        test_bin_windows();
        test_global_long_frame();
        test_random_frames();
        drain();

        $display("Sent %0d bins and checked %0d results over all three modes and mode three.",
                 bins_sent, results_seen);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
